// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/mbq_pkg.sv =====
// ----------------------------------------------------------------------------
// mbq_pkg
// Shared widths, register indexes, reset values and helpers of the filter bank.
// ----------------------------------------------------------------------------
package mbq_pkg;

  localparam int CHANNELS  = 16;
  localparam int CH_W      = 4;
  localparam int SAMPLE_W  = 24;
  localparam int ST_W      = 48;
  localparam int COEF_W    = 34;
  localparam int SCALE_W   = 33;
  localparam int CNT_W     = 16;
  localparam int ACC_W     = 54;
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 24;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 3;
  localparam int TDATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_TWO      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_ONE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FF_TWO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FF_ONE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_COUNT = 3'd5;

  localparam logic [SCALE_W-1:0]       RST_INPUT_SCALE = 33'd107893;
  localparam logic signed [COEF_W-1:0] RST_FB_TWO      = 34'sd1052323368;
  localparam logic signed [COEF_W-1:0] RST_FB_ONE      = -34'sd2125849407;
  localparam logic signed [COEF_W-1:0] RST_FF_TWO      = 34'sd1073741824;
  localparam logic signed [COEF_W-1:0] RST_FF_ONE      = 34'sd2147483648;
  localparam logic [CNT_W-1:0]         RST_PRIME_COUNT = 16'd10000;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  function automatic logic [ST_W-1:0] mag_st(input logic signed [ST_W-1:0] v);
    mag_st = v[ST_W-1] ? (ST_W'(0) - v) : v;
  endfunction

  function automatic logic [COEF_W-1:0] mag_coef(input logic signed [COEF_W-1:0] v);
    mag_coef = v[COEF_W-1] ? (COEF_W'(0) - v) : v;
  endfunction

endpackage

// ===== rtl/multichannel_biquad_lowpass_bank_core.sv =====
// ----------------------------------------------------------------------------
// multichannel_biquad_lowpass_bank_core
// Sixteen-channel second-order low-pass filter bank on one shared multiplier.
// ----------------------------------------------------------------------------
// Input beats carry a channel and a sample in in_tdata and the operation in
// in_tuser: filter the sample, or reset the channel to it. A filter beat gives
// one output beat with the channel and the rounded, saturated result; a reset
// beat gives none. Coefficients are to be written on the cfg port while idle;
// the block itself does not enforce it. In a filter pass nine products go
// through the single 34x24 multiplier, one per cycle; then the last term is
// added, and the result is saturated and the state updated.
// An item runs N filter passes before in_tready returns, where N is one,
// plus prime_count if the channel was never used, plus prime_count for a
// reset beat. in_tready is low while an item is in work.
// A finished result sits in the output register; the next item is taken
// meanwhile, and only its own write-back waits if the receiver still stalls.
// Reset sets the registers to their defaults and marks every channel unused,
// so each channel's first sample primes it from zero, if prime_count is set.
// ----------------------------------------------------------------------------
module multichannel_biquad_lowpass_bank_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mbq_pkg::TDATA_W-1:0]       in_tdata,   // channel, sample
  input  logic                              in_tuser,   // opcode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mbq_pkg::TDATA_W-1:0]       out_tdata,  // out_channel, filtered
  input  logic                              cfg_we,
  input  logic [mbq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbq_pkg::COEF_W-1:0]        cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  localparam logic [1:0] MODE_PRIME1 = 2'd0;
  localparam logic [1:0] MODE_FILT   = 2'd1;
  localparam logic [1:0] MODE_PRIME2 = 2'd2;

  localparam logic [3:0] PH_LAST = 4'd10;

  localparam int ST_W  = mbq_pkg::ST_W;
  localparam int ACC_W = mbq_pkg::ACC_W;
  localparam int SW    = mbq_pkg::SAMPLE_W;

  localparam logic signed [ST_W-1:0]  ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
  localparam logic signed [ST_W-1:0]  ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

  logic [mbq_pkg::SCALE_W-1:0]       scale_r;
  logic signed [mbq_pkg::COEF_W-1:0] fb2_r, fb1_r, ff2_r, ff1_r;
  logic [mbq_pkg::CNT_W-1:0]         pcount_r;

  logic [1:0] state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [3:0] ph_r, ph_nxt;
  logic [mbq_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic op_r;
  logic [mbq_pkg::CH_W-1:0] ch_r;
  logic signed [SW-1:0] x_r;
  logic [mbq_pkg::CHANNELS-1:0] live_r;
  logic out_valid_r, out_valid_nxt;
  logic [mbq_pkg::CH_W-1:0] out_ch_r;
  logic [SW-1:0] out_val_r;

  logic signed [ST_W-1:0] s1_mem_r [mbq_pkg::CHANNELS];
  logic signed [ST_W-1:0] s2_mem_r [mbq_pkg::CHANNELS];
  logic signed [ST_W-1:0] y1_mem_r [mbq_pkg::CHANNELS];
  logic signed [ST_W-1:0] y2_mem_r [mbq_pkg::CHANNELS];

  logic signed [ST_W-1:0] s1_r, s2_r, y1_r, y2_r, snew_r;
  logic signed [ST_W-1:0] s1_nxt, s2_nxt, y1_nxt, y2_nxt, snew_nxt;
  logic [mbq_pkg::PROD_W-1:0] ah_r, ah_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  logic [mbq_pkg::MUL_A_W-1:0] mul_a;
  logic [mbq_pkg::MUL_B_W-1:0] mul_b;
  logic [mbq_pkg::PROD_W-1:0]  prod_r;

  logic accept, emit, wb_go;
  logic [ST_W-1:0] mag_s1, mag_s2, mag_y1, mag_y2;
  logic [SW-1:0] x_mag;
  logic [52:0] sc_r, sc_cap;
  logic [58:0] t_sum;
  logic [52:0] term_mag;
  logic term_neg, term_sub;
  logic signed [ACC_W-1:0] term_val;
  logic signed [ST_W-1:0] y_sat;
  logic [ST_W:0] ymag_rnd;
  logic [24:0] y_r25;
  logic [SW-1:0] y_out;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign emit      = (op_r == mbq_pkg::OP_FILTER);
  assign wb_go     = (state_r == ST_WB) && !(emit && out_valid_r && !out_tready);

  assign mag_s1 = mbq_pkg::mag_st(s1_r);
  assign mag_s2 = mbq_pkg::mag_st(s2_r);
  assign mag_y1 = mbq_pkg::mag_st(y1_r);
  assign mag_y2 = mbq_pkg::mag_st(y2_r);
  assign x_mag  = x_r[SW-1] ? (SW'(0) - x_r) : x_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ph_r)
      4'd0: begin mul_a = {1'b0, scale_r};            mul_b = x_mag;        end
      4'd1: begin mul_a = mbq_pkg::mag_coef(ff2_r);   mul_b = mag_s2[47:24]; end
      4'd2: begin mul_a = mbq_pkg::mag_coef(ff2_r);   mul_b = mag_s2[23:0];  end
      4'd3: begin mul_a = mbq_pkg::mag_coef(ff1_r);   mul_b = mag_s1[47:24]; end
      4'd4: begin mul_a = mbq_pkg::mag_coef(ff1_r);   mul_b = mag_s1[23:0];  end
      4'd5: begin mul_a = mbq_pkg::mag_coef(fb2_r);   mul_b = mag_y2[47:24]; end
      4'd6: begin mul_a = mbq_pkg::mag_coef(fb2_r);   mul_b = mag_y2[23:0];  end
      4'd7: begin mul_a = mbq_pkg::mag_coef(fb1_r);   mul_b = mag_y1[47:24]; end
      4'd8: begin mul_a = mbq_pkg::mag_coef(fb1_r);   mul_b = mag_y1[23:0];  end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  mbq_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  always_comb begin
    sc_r = prod_r[57:6] + 53'(prod_r[5]);
    if (sc_r > 53'h800000000000) begin
      sc_cap = 53'h800000000000;
    end else begin
      sc_cap = sc_r;
    end
    t_sum = {29'd0, ah_r[5:0], 24'd0} + {1'b0, prod_r} + 59'h20000000;
    term_mag = 53'(ah_r[57:6]) + 53'(t_sum[58:30]);
    term_neg = 1'b0;
    term_sub = 1'b0;
    case (ph_r)
      4'd3: begin term_neg = ff2_r[mbq_pkg::COEF_W-1] ^ s2_r[ST_W-1]; term_sub = 1'b0; end
      4'd5: begin term_neg = ff1_r[mbq_pkg::COEF_W-1] ^ s1_r[ST_W-1]; term_sub = 1'b0; end
      4'd7: begin term_neg = fb2_r[mbq_pkg::COEF_W-1] ^ y2_r[ST_W-1]; term_sub = 1'b1; end
      4'd9: begin term_neg = fb1_r[mbq_pkg::COEF_W-1] ^ y1_r[ST_W-1]; term_sub = 1'b1; end
      default: begin term_neg = 1'b0; term_sub = 1'b0; end
    endcase
    term_val = (term_neg ^ term_sub) ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
    if (acc_r > ACC_W'(ST_MAX)) begin
      y_sat = ST_MAX;
    end else if (acc_r < ACC_W'(ST_MIN)) begin
      y_sat = ST_MIN;
    end else begin
      y_sat = acc_r[ST_W-1:0];
    end
    ymag_rnd = {1'b0, mag_y1} + (ST_W+1)'(24'h800000);
    y_r25    = ymag_rnd[48:24];
    if (y1_r[ST_W-1]) begin
      y_out = (y_r25 > 25'h800000) ? 24'h800000 : SW'(25'd0 - y_r25);
    end else begin
      y_out = (y_r25 > 25'h7FFFFF) ? 24'h7FFFFF : y_r25[SW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    ph_nxt        = ph_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    s1_nxt   = s1_r;
    s2_nxt   = s2_r;
    y1_nxt   = y1_r;
    y2_nxt   = y2_r;
    snew_nxt = snew_r;
    ah_nxt   = ah_r;
    acc_nxt  = acc_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (live_r[ch_r]) begin
          s1_nxt = s1_mem_r[ch_r];
          s2_nxt = s2_mem_r[ch_r];
          y1_nxt = y1_mem_r[ch_r];
          y2_nxt = y2_mem_r[ch_r];
        end else begin
          s1_nxt = '0;
          s2_nxt = '0;
          y1_nxt = '0;
          y2_nxt = '0;
        end
        if (!live_r[ch_r] && (pcount_r != '0)) begin
          mode_nxt = MODE_PRIME1;
          rem_nxt  = pcount_r;
        end else begin
          mode_nxt = MODE_FILT;
        end
        ph_nxt    = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        ph_nxt = ph_r + 4'd1;
        if (ph_r == 4'd1) begin
          snew_nxt = x_r[SW-1] ? (ST_W'(0) - sc_cap[ST_W-1:0])
                               : ((sc_cap > 53'h7FFFFFFFFFFF) ? ST_MAX : sc_cap[ST_W-1:0]);
          acc_nxt  = ACC_W'(x_r[SW-1] ? -$signed({1'b0, sc_cap}) : $signed({1'b0,
                     ((sc_cap > 53'h7FFFFFFFFFFF) ? 53'h7FFFFFFFFFFF : sc_cap)}));
        end else if (ph_r == 4'd2 || ph_r == 4'd4 || ph_r == 4'd6 || ph_r == 4'd8) begin
          ah_nxt = prod_r;
        end else if (ph_r == 4'd3 || ph_r == 4'd5 || ph_r == 4'd7 || ph_r == 4'd9) begin
          acc_nxt = acc_r + term_val;
        end else if (ph_r == PH_LAST) begin
          ph_nxt = '0;
          s2_nxt = s1_r;
          s1_nxt = snew_r;
          y2_nxt = y1_r;
          y1_nxt = y_sat;
          case (mode_r)
            MODE_PRIME1: begin
              rem_nxt = rem_r - 16'd1;
              if (rem_r == 16'd1) begin
                mode_nxt = MODE_FILT;
              end
            end
            MODE_FILT: begin
              if (op_r == mbq_pkg::OP_RESET && pcount_r != '0) begin
                mode_nxt = MODE_PRIME2;
                rem_nxt  = pcount_r;
              end else begin
                state_nxt = ST_WB;
              end
            end
            MODE_PRIME2: begin
              rem_nxt = rem_r - 16'd1;
              if (rem_r == 16'd1) begin
                state_nxt = ST_WB;
              end
            end
            default: begin
              state_nxt = ST_WB;
            end
          endcase
        end
      end
      ST_WB: begin
        if (wb_go) begin
          state_nxt = ST_IDLE;
          if (emit) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_FILT;
      ph_r        <= '0;
      rem_r       <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      scale_r     <= mbq_pkg::RST_INPUT_SCALE;
      fb2_r       <= mbq_pkg::RST_FB_TWO;
      fb1_r       <= mbq_pkg::RST_FB_ONE;
      ff2_r       <= mbq_pkg::RST_FF_TWO;
      ff1_r       <= mbq_pkg::RST_FF_ONE;
      pcount_r    <= mbq_pkg::RST_PRIME_COUNT;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      ph_r        <= ph_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      if (wb_go) begin
        live_r[ch_r] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          mbq_pkg::REG_INPUT_SCALE: scale_r  <= cfg_wdata[mbq_pkg::SCALE_W-1:0];
          mbq_pkg::REG_FB_TWO:      fb2_r    <= cfg_wdata;
          mbq_pkg::REG_FB_ONE:      fb1_r    <= cfg_wdata;
          mbq_pkg::REG_FF_TWO:      ff2_r    <= cfg_wdata;
          mbq_pkg::REG_FF_ONE:      ff1_r    <= cfg_wdata;
          mbq_pkg::REG_PRIME_COUNT: pcount_r <= cfg_wdata[mbq_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_r   <= s1_nxt;
    s2_r   <= s2_nxt;
    y1_r   <= y1_nxt;
    y2_r   <= y2_nxt;
    snew_r <= snew_nxt;
    ah_r   <= ah_nxt;
    acc_r  <= acc_nxt;
    if (accept) begin
      op_r <= in_tuser;
      ch_r <= in_tdata[mbq_pkg::CH_W-1:0];
      x_r  <= in_tdata[mbq_pkg::CH_W +: SW];
    end
    if (wb_go) begin
      s1_mem_r[ch_r] <= s1_r;
      s2_mem_r[ch_r] <= s2_r;
      y1_mem_r[ch_r] <= y1_r;
      y2_mem_r[ch_r] <= y2_r;
      if (emit) begin
        out_ch_r  <= ch_r;
        out_val_r <= y_out;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_val_r, out_ch_r};

endmodule

// ===== rtl/mbq_mul.sv =====
// ----------------------------------------------------------------------------
// mbq_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mbq_mul (
  input  logic                          clk,
  input  logic [mbq_pkg::MUL_A_W-1:0]   op_a,
  input  logic [mbq_pkg::MUL_B_W-1:0]   op_b,
  output logic [mbq_pkg::PROD_W-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mbq_pkg::PROD_W'(op_a) * mbq_pkg::PROD_W'(op_b);
  end

endmodule

// ===== rtl/mbq_checker.sv =====
// ----------------------------------------------------------------------------
// mbq_checker
// Port-level checks of the filter bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mbq_pkg::TDATA_W-1:0]   out_tdata
);

  `MBQ_ASSERT_NEXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready)
  `MBQ_ASSERT_NEXT(a_busy_two_cycles, in_tvalid && in_tready, ##1 !in_tready)
  `MBQ_ASSERT_IMPL(a_result_from_work, $rose(out_tvalid), $past(!in_tready))
  `MBQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind multichannel_biquad_lowpass_bank_core mbq_checker u_mbq_checker (.*);

// ===== bench/multichannel_biquad_lowpass_bank_core_tb.sv =====
// ----------------------------------------------------------------------------
// multichannel_biquad_lowpass_bank_core_tb
// Self-checking bench for the sixteen-channel biquad low-pass bank. A directed
// table covers sample extremes, both operations, fresh and reset channels and
// zero-state results. Random phases follow under many coefficient settings.
// Each output beat is checked against a typed table value or a bit-true
// fixed-point bench model. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module multichannel_biquad_lowpass_bank_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int    WATCHDOG_LIMIT = 2500000;
  localparam int    PHASES         = 8;
  localparam int    PHASE_BEATS    = 100;
  localparam longint SCALE_MAX     = 64'h1_FFFF_FFFF;
  localparam longint COEF_MAX      = 64'h1_FFFF_FFFF;
  localparam longint COEF_MIN      = -64'sh2_0000_0000;
  localparam longint SAT_HI        = 64'sd140737488355327;
  localparam longint SAT_LO        = -64'sd140737488355328;

  typedef struct {
    logic op;
    int   ch;
    int   smp;
    bit   typed;
    int   want;
  } stim_row_t;

  typedef struct {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] filt;
  } filt_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata = '0;
  logic                 in_tuser = OP_FILTER;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_INPUT_SCALE;
  logic [COEF_W-1:0]    cfg_wdata = '0;

  multichannel_biquad_lowpass_bank_core u_top (.*);

  // Filter state mirrored in the bench.
  longint gain_recip, fb_two, fb_one, ff_two, ff_one;
  int     prime_iters;
  longint sc_z1[CHANNELS], sc_z2[CHANNELS], y_z1[CHANNELS], y_z2[CHANNELS];
  bit     ch_live[CHANNELS];

  filt_result_t pending_outputs[$];
  int  mismatches = 0;
  int  burst_left = 8;
  bit  hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sat48(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint coef_mul(longint c, longint st);
    bit neg;
    longint unsigned mc, ms, ah, al, t, r;
    neg = (c < 0) != (st < 0);
    mc = mag64(c);
    ms = mag64(st);
    ah = mc * (ms >> 24);
    al = mc * (ms & 64'hFF_FFFF);
    t = ((ah & 64'd63) << 24) + al + (64'd1 << 29);
    r = (ah >> 6) + (t >> 30);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint scale_in(longint x);
    longint unsigned p, r;
    p = mag64(x) * longint'(gain_recip);
    r = (p >> 6) + ((p >> 5) & 64'd1);
    if (r > 64'd140737488355328) r = 64'd140737488355328;
    return sat48((x < 0) ? -longint'(r) : longint'(r));
  endfunction

  function automatic longint biquad_pass(int ch, longint x);
    longint s, y;
    s = scale_in(x);
    y = s + coef_mul(ff_two, sc_z2[ch]) + coef_mul(ff_one, sc_z1[ch])
          - coef_mul(fb_two, y_z2[ch]) - coef_mul(fb_one, y_z1[ch]);
    y = sat48(y);
    sc_z2[ch] = sc_z1[ch];
    sc_z1[ch] = s;
    y_z2[ch]  = y_z1[ch];
    y_z1[ch]  = y;
    return y;
  endfunction

  function automatic void prime_channel(int ch, longint x);
    for (int i = 0; i < prime_iters; i++) void'(biquad_pass(ch, x));
  endfunction

  function automatic logic [SAMPLE_W-1:0] round_to_sample(longint y);
    longint unsigned r;
    longint v;
    r = (mag64(y) + (64'd1 << 23)) >> 24;
    v = (y < 0) ? -longint'(r) : longint'(r);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[SAMPLE_W-1:0];
  endfunction

  // Returns 1 and the rounded output when the operation produces a beat.
  function automatic bit filter_bank_step(logic op, int ch, int smp,
                                          output logic [SAMPLE_W-1:0] filt);
    longint x, y;
    x = longint'(signed'(smp[SAMPLE_W-1:0]));
    if (!ch_live[ch]) begin
      prime_channel(ch, x);
      ch_live[ch] = 1'b1;
    end
    y = biquad_pass(ch, x);
    filt = round_to_sample(y);
    if (op == OP_RESET) begin
      prime_channel(ch, x);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[COEF_W-1:0];
    case (idx)
      REG_INPUT_SCALE: gain_recip = val & SCALE_MAX;
      REG_FB_TWO:      fb_two = longint'(signed'(val[COEF_W-1:0]));
      REG_FB_ONE:      fb_one = longint'(signed'(val[COEF_W-1:0]));
      REG_FF_TWO:      ff_two = longint'(signed'(val[COEF_W-1:0]));
      REG_FF_ONE:      ff_one = longint'(signed'(val[COEF_W-1:0]));
      REG_PRIME_COUNT: prime_iters = int'(val[CNT_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(logic op, int ch, int smp, bit typed, int want);
    logic [SAMPLE_W-1:0] filt;
    filt_result_t res;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, smp[SAMPLE_W-1:0], ch[CH_W-1:0]};
    do @(posedge clk); while (!in_tready);
    if (filter_bank_step(op, ch, smp, filt)) begin
      res.ch = ch[CH_W-1:0];
      res.filt = typed ? want[SAMPLE_W-1:0] : filt;
      pending_outputs.push_back(res);
    end
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_tready) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_settings(longint sc, longint f2, longint f1, longint g2,
                               longint g1, int pc);
    write_reg(REG_INPUT_SCALE, sc);
    write_reg(REG_FB_TWO, f2);
    write_reg(REG_FB_ONE, f1);
    write_reg(REG_FF_TWO, g2);
    write_reg(REG_FF_ONE, g1);
    write_reg(REG_PRIME_COUNT, pc);
  endtask

  function automatic longint rand_coef();
    return longint'({$urandom, $urandom}) % 64'sd8589934592;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return 8388607;
      1: return -8388608;
      2: return $urandom_range(0, 3) - 2;
      default: return int'({$urandom} & 32'hFF_FFFF);
    endcase
  endfunction

  // Receiver: random stall pattern plus one long hold on request.
  int hold_left = 0, rx_mode = 0, rx_mode_left = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(16, 96);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    filt_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h", out_tdata);
      end else begin
        exp_res = pending_outputs.pop_front();
        if (out_tdata[CH_W-1:0] !== exp_res.ch ||
            out_tdata[CH_W +: SAMPLE_W] !== exp_res.filt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ch %0d y %h, got ch %0d y %h",
                     exp_res.ch, exp_res.filt, out_tdata[CH_W-1:0],
                     out_tdata[CH_W +: SAMPLE_W]);
        end
      end
    end
  end

  int stalled = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stalled = 0;
    end else begin
      stalled++;
      if (stalled == WATCHDOG_LIMIT) begin
        $display("multichannel_biquad_lowpass_bank_core_tb: FAIL");
        $finish;
      end
    end
  end

  stim_row_t dir_rows[] = '{
    '{OP_FILTER, 1, 0, 1'b1, 0},
    '{OP_FILTER, 1, 0, 1'b1, 0},
    '{OP_FILTER, 2, 8388607, 1'b0, 0},
    '{OP_FILTER, 2, 8388607, 1'b0, 0},
    '{OP_FILTER, 3, -8388608, 1'b0, 0},
    '{OP_FILTER, 3, -8388608, 1'b0, 0},
    '{OP_FILTER, 4, 1, 1'b0, 0},
    '{OP_FILTER, 4, -1, 1'b0, 0},
    '{OP_RESET, 5, 8388607, 1'b0, 0},
    '{OP_FILTER, 5, 0, 1'b0, 0},
    '{OP_FILTER, 0, 0, 1'b0, 0},
    '{OP_RESET, 6, 0, 1'b0, 0},
    '{OP_FILTER, 6, 0, 1'b1, 0},
    '{OP_FILTER, 15, 5592405, 1'b0, 0},
    '{OP_FILTER, 15, -5592406, 1'b0, 0},
    '{OP_RESET, 7, -8388608, 1'b0, 0},
    '{OP_RESET, 7, 100, 1'b0, 0},
    '{OP_FILTER, 7, 100, 1'b0, 0},
    '{OP_FILTER, 0, 8388607, 1'b0, 0}
  };

  longint ph_scale[PHASES] = '{107893, 0, SCALE_MAX, 107893, 1073741824, 0, 0, 107893};
  longint ph_fb2[PHASES]   = '{1052323368, 1052323368, 1052323368, COEF_MIN, 0, 0, 0,
                               1052323368};
  longint ph_fb1[PHASES]   = '{-2125849407, -2125849407, -2125849407, COEF_MAX, 0, 0, 0,
                               -2125849407};
  longint ph_ff2[PHASES]   = '{1073741824, 1073741824, 1073741824, COEF_MAX, 0, 0, 0,
                               1073741824};
  longint ph_ff1[PHASES]   = '{2147483648, 2147483648, 2147483648, COEF_MIN, 0, 0, 0,
                               2147483648};
  int     ph_prime[PHASES] = '{0, 1, 3, 2, 5, 0, 0, 4};

  initial begin
    gain_recip = RST_INPUT_SCALE;
    fb_two = RST_FB_TWO;
    fb_one = RST_FB_ONE;
    ff_two = RST_FF_TWO;
    ff_one = RST_FF_ONE;
    prime_iters = RST_PRIME_COUNT;
    foreach (ch_live[i]) begin
      sc_z1[i] = 0; sc_z2[i] = 0; y_z1[i] = 0; y_z2[i] = 0; ch_live[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults, full priming run on a fresh channel.
    send_beat(OP_FILTER, 0, 8388607, 1'b0, 0);
    drain_and_settle();

    write_reg(REG_PRIME_COUNT, 2);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].smp,
                dir_rows[i].typed, dir_rows[i].want);
    drain_and_settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph >= 5)
        load_settings($urandom_range(0, 1) ? longint'({$urandom} % 2000000)
                                           : longint'({$urandom, $urandom}) & SCALE_MAX,
                      rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                      $urandom_range(0, 7));
      else
        load_settings(ph_scale[ph], ph_fb2[ph], ph_fb1[ph], ph_ff2[ph], ph_ff1[ph],
                      ph_prime[ph]);
      write_reg(REG_SPARE_LO, rand_coef());
      write_reg(REG_SPARE_HI, rand_coef());
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n == PHASE_BEATS / 2 && ph == 4) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
          while (pending_outputs.size() != 0) @(posedge clk);
        end
        send_beat(($urandom_range(0, 99) < 85) ? OP_FILTER : OP_RESET,
                  $urandom_range(0, CHANNELS - 1), rand_sample(), 1'b0, 0);
      end
      drain_and_settle();
    end

    // Longest priming run, one reset beat, then a filter beat after it.
    write_reg(REG_PRIME_COUNT, 65535);
    send_beat(OP_RESET, 1, -8388608, 1'b0, 0);
    send_beat(OP_FILTER, 1, 8388607, 1'b0, 0);
    drain_and_settle();

    if (mismatches == 0) begin
      $display("multichannel_biquad_lowpass_bank_core_tb: PASS");
    end else begin
      $display("multichannel_biquad_lowpass_bank_core_tb: FAIL");
    end
    $finish;
  end

endmodule
